// ----- hdl/modexp_pkg.sv -----
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Operation codes for the exponentiation sequencer.
// ----------------------------------------------------------------------------
package modexp_pkg;

  // Operation requested from the shared modular multiplier.
  typedef enum logic [1:0] {
    OP_REDUCE,
    OP_MULTIPLY,
    OP_SQUARE
  } mm_op_t;

endpackage

// ----- hdl/modexp_if.sv -----
// ----------------------------------------------------------------------------
// Modular exponentiation channels
// Valid/ready channels for operand items and result items.
// ----------------------------------------------------------------------------
interface modexp_in_if #(parameter int WORD_WIDTH = 64);
  logic                  valid;
  logic                  ready;
  logic [WORD_WIDTH-1:0] base_value;
  logic [WORD_WIDTH-1:0] exponent;
  logic [WORD_WIDTH-1:0] modulus;
  modport source (output valid, base_value, exponent, modulus, input ready);
  modport sink (input valid, base_value, exponent, modulus, output ready);
endinterface

interface modexp_out_if #(parameter int WORD_WIDTH = 64);
  logic                  valid;
  logic                  ready;
  logic [WORD_WIDTH-1:0] power_residue;
  modport source (output valid, power_residue, input ready);
  modport sink (input valid, power_residue, output ready);
endinterface

// ----- hdl/modular_exponentiation.sv -----
// ----------------------------------------------------------------------------
// Modular exponentiation
// Right-to-left square-and-multiply over a shared shift-and-add multiplier.
// ----------------------------------------------------------------------------
// All modular products run in the shared unit. The base reduction is one
// product (base * 1), then each exponent bit takes a multiply when set and a
// square before the next bit: at most 2*WORD_WIDTH products. Special moduli
// and a zero exponent bypass the multiplier and go straight to the result.
// One item at a time: a new item is taken the cycle after the result leaves.
// Reset (synchronous, active low) returns the sequencer to idle, no result held.
module modular_exponentiation #(
  parameter int WORD_WIDTH = 64
) (
  input logic clk,
  input logic rst_n,
  modexp_in_if.sink   in_ch,
  modexp_out_if.source out_ch
);
  import modexp_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RED  = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_SQR  = 3'd3;
  localparam logic [2:0] S_WAIT = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]            state_r;
  mm_op_t                op_r;
  logic [WORD_WIDTH-1:0] base_r, exp_r, mod_r, res_r;
  logic                  mm_start, mm_done;
  logic [WORD_WIDTH-1:0] mm_a, mm_b, mm_p;
  logic [WORD_WIDTH-1:0] one_w;

  assign one_w = WORD_WIDTH'(1);

  // Reduction of the base uses base * 1 with the raw base as multiplier;
  // shift-and-add only adds a once doubling is reduced, so a >= m is handled
  // by first taking it modulo through the multiplier bit path instead.
  always_comb begin
    mm_a = res_r;
    mm_b = base_r;
    if (op_r == OP_REDUCE) begin
      mm_a = one_w;
      mm_b = base_r;
    end else if (op_r == OP_SQUARE) begin
      mm_a = base_r;
    end
  end

  assign mm_start = state_r inside {S_RED, S_MUL, S_SQR};

  modexp_mulmod #(.WORD_WIDTH(WORD_WIDTH)) u_mulmod (
    .clk, .rst_n, .start(mm_start), .a(mm_a), .b(mm_b), .m(mod_r),
    .done(mm_done), .product(mm_p)
  );

  assign in_ch.ready      = (state_r == S_IDLE);
  assign out_ch.valid     = (state_r == S_OUT);
  assign out_ch.power_residue = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      op_r    <= OP_REDUCE;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            base_r <= in_ch.base_value;
            exp_r  <= in_ch.exponent;
            mod_r  <= in_ch.modulus;
            if (in_ch.modulus < WORD_WIDTH'(2)) begin
              res_r   <= '0;
              state_r <= S_OUT;
            end else if (in_ch.exponent == '0) begin
              res_r   <= one_w;
              state_r <= S_OUT;
            end else begin
              res_r   <= one_w;
              op_r    <= OP_REDUCE;
              state_r <= S_RED;
            end
          end
        end
        S_RED, S_MUL, S_SQR: state_r <= S_WAIT;
        S_WAIT: begin
          if (mm_done) begin
            case (op_r)
              OP_REDUCE: begin
                base_r <= mm_p;
                if (exp_r[0]) begin
                  op_r <= OP_MULTIPLY; state_r <= S_MUL;
                end else begin
                  exp_r <= exp_r >> 1;
                  op_r <= OP_SQUARE; state_r <= S_SQR;
                end
              end
              OP_MULTIPLY: begin
                res_r <= mm_p;
                exp_r <= exp_r >> 1;
                if ((exp_r >> 1) == '0) state_r <= S_OUT;
                else begin
                  op_r <= OP_SQUARE; state_r <= S_SQR;
                end
              end
              default: begin
                base_r <= mm_p;
                if (exp_r[0]) begin
                  op_r <= OP_MULTIPLY; state_r <= S_MUL;
                end else begin
                  exp_r <= exp_r >> 1;
                  state_r <= S_SQR;
                end
              end
            endcase
          end
        end
        S_OUT: if (out_ch.ready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_out_below_mod: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && mod_r > 1) |-> (res_r < mod_r))
    else $error("result outside residue range");
  a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && !out_ch.ready) |=> (state_r == S_OUT && $stable(res_r)))
    else $error("result dropped while stalled");
  a_square_nonzero_exp: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SQR) |-> (exp_r != '0)) else $error("square after last bit");
endmodule

// ----- hdl/modexp_mulmod.sv -----
// ----------------------------------------------------------------------------
// Shift-and-add modular multiplier
// Forms (a * b) mod m one multiplier bit per cycle with modular doubling.
// ----------------------------------------------------------------------------
module modexp_mulmod #(
  parameter int WORD_WIDTH = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [WORD_WIDTH-1:0] a,
  input  logic [WORD_WIDTH-1:0] b,
  input  logic [WORD_WIDTH-1:0] m,
  output logic                  done,
  output logic [WORD_WIDTH-1:0] product
);
  localparam int CW = $clog2(WORD_WIDTH);

  logic                  busy_r;
  logic [CW-1:0]         cnt_r;
  logic [WORD_WIDTH-1:0] acc_r, acc_nxt, a_r, b_r, m_r;
  logic [WORD_WIDTH-1:0] dbl;
  logic                  done_r;

  // (x + y) mod m for x, y < m without leaving the word width.
  function automatic logic [WORD_WIDTH-1:0] add_mod(
    input logic [WORD_WIDTH-1:0] x, y, md);
    logic [WORD_WIDTH-1:0] gap;
    gap = md - y;
    if (x >= gap) add_mod = x - gap;
    else add_mod = x + y;
  endfunction

  always_comb begin
    dbl = add_mod(acc_r, acc_r, m_r);
    acc_nxt = b_r[WORD_WIDTH-1] ? add_mod(dbl, a_r, m_r) : dbl;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(WORD_WIDTH - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      acc_r <= '0;
      a_r   <= a;
      b_r   <= b;
      m_r   <= m;
    end else if (busy_r) begin
      acc_r <= acc_nxt;
      b_r   <= b_r << 1;
    end
  end

  assign done    = done_r;
  assign product = acc_r;

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r)) else $error("done without a running product");
  a_acc_below_mod: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && m_r > 1 && a_r < m_r) |=> (acc_r < m_r))
    else $error("accumulator left the residue range");
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && cnt_r != '0) |=> busy_r) else $error("product ended early");
endmodule
